// ===== design/acc_pkg.sv =====
// Shared types and constants of the 16-bit accumulator core.
`default_nettype none
package acc_pkg;

  typedef logic [15:0] word_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
    word_t rem;
  } div_rsp_t;

  // register indexes
  localparam logic [2:0] R_SP  = 3'd0;
  localparam logic [2:0] R_PC  = 3'd1;
  localparam logic [2:0] R_FL  = 3'd2;
  localparam logic [2:0] R_ACC = 3'd7;

  // opcodes
  localparam logic [7:0] OP_MOV     = 8'h00;
  localparam logic [7:0] OP_LDI_X   = 8'h01;
  localparam logic [7:0] OP_LDI_ACC = 8'h05;
  localparam logic [7:0] OP_LDM_X   = 8'h06;
  localparam logic [7:0] OP_LDM_ACC = 8'h0A;
  localparam logic [7:0] OP_LDR     = 8'h0B;
  localparam logic [7:0] OP_STR     = 8'h0C;
  localparam logic [7:0] OP_STM_X   = 8'h0D;
  localparam logic [7:0] OP_STM_ACC = 8'h11;
  localparam logic [7:0] OP_ALU     = 8'h12;
  localparam logic [7:0] OP_CMP     = 8'h13;
  localparam logic [7:0] OP_CMPI    = 8'h14;
  localparam logic [7:0] OP_SKIP    = 8'h15;
  localparam logic [7:0] OP_JREL    = 8'h16;
  localparam logic [7:0] OP_JREG    = 8'h17;
  localparam logic [7:0] OP_JMP     = 8'h18;
  localparam logic [7:0] OP_JR      = 8'h19;
  localparam logic [7:0] OP_PUSH    = 8'h1A;
  localparam logic [7:0] OP_PUSHI   = 8'h1B;
  localparam logic [7:0] OP_POP     = 8'h1C;
  localparam logic [7:0] OP_CALL    = 8'h1D;
  localparam logic [7:0] OP_RET     = 8'h1E;
  localparam logic [7:0] OP_INC     = 8'h1F;

  // arithmetic ops
  localparam logic [7:0] ALU_ADD = 8'h00;
  localparam logic [7:0] ALU_SUB = 8'h01;
  localparam logic [7:0] ALU_MUL = 8'h02;
  localparam logic [7:0] ALU_DIV = 8'h03;
  localparam logic [7:0] ALU_MOD = 8'h04;
  localparam logic [7:0] ALU_SHR = 8'h05;
  localparam logic [7:0] ALU_SHL = 8'h06;
  localparam logic [7:0] ALU_AND = 8'h07;
  localparam logic [7:0] ALU_OR  = 8'h08;
  localparam logic [7:0] ALU_XOR = 8'h09;
  localparam logic [7:0] ALU_NOT = 8'h0A;
  localparam logic [7:0] ALU_INC = 8'h0B;

  // skip modes
  localparam logic [7:0] SK_NLT = 8'h00;
  localparam logic [7:0] SK_NGT = 8'h01;
  localparam logic [7:0] SK_NLE = 8'h02;
  localparam logic [7:0] SK_NGE = 8'h03;
  localparam logic [7:0] SK_NEQ = 8'h04;
  localparam logic [7:0] SK_LE  = 8'h05;

  localparam word_t VEC_ADDR  = 16'hff02;
  localparam word_t ALL_ONES  = 16'hffff;
  localparam word_t OFS_MASK  = 16'h7fff;

endpackage
`default_nettype wire

// ===== design/accumulator_cpu_core_16bit.sv =====
// Top level: register file, sequencer and data memory of the accumulator core.
//
//   channel | handshake           | word
//   --------+---------------------+-------------------------------------------
//   in      | in_valid_i/in_ready_o | req_type, opcode, dest_sel, src_sel
//   out     | out_valid_o/out_ready_i | next_pc .. accum, irq_taken
//
// An instruction runs S_DEC, S_EXEC and S_FIN from accept to result; a word
// read from memory adds S_RHI and S_RDY, a word write adds S_WLO and S_WHI
// (byte-wide RAM port), divide and remainder add S_DIV for the serial divider.
// After reset a clearing pass writes zero to every RAM byte, with in_ready_o
// low. A result waiting in the output register stalls only the next S_FIN state.
`default_nettype none
module accumulator_cpu_core_16bit #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  opcode_i,
  input  wire logic [7:0]  dest_sel_i,
  input  wire logic [7:0]  src_sel_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [15:0] next_pc_o,
  output logic      [15:0] stack_ptr_o,
  output logic      [2:0]  flag_bits_o,
  output logic      [15:0] reg_x_o,
  output logic      [15:0] reg_y_o,
  output logic      [15:0] reg_a_o,
  output logic      [15:0] reg_b_o,
  output logic      [15:0] accum_o,
  output logic             irq_taken_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_RHI, S_RDY, S_DIV, S_EXEC, S_WLO, S_WHI, S_FIN
  } state_e;

  state_e               state_q;
  logic [ADDR_BITS-1:0] clr_q;
  logic                 req_q;
  logic [7:0]           op_q, d_q, s_q;
  logic [15:0]          regs_q [8];
  logic [15:0]          regs_n [8];
  logic [7:0]           lo_q;
  logic [15:0]          word_q;
  logic                 wr_q, wr_n;
  logic [15:0]          waddr_q, waddr_n, wdata_q, wdata_n;
  logic                 taken_q, taken_n;
  logic                 out_valid_q;

  logic [15:0] imm, pcn, rv_d, rv_s, sp_dec, acc, v, rd_addr;
  logic [2:0]  rd, rs;
  logic        needs_rd, is_div, skip;
  logic [31:0] prod;
  logic [2:0]  fl;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr, ra_lo, ra_hi;
  logic [7:0]           ram_wdata, ram_rdata;

  acc_pkg::div_req_t div_req;
  acc_pkg::div_rsp_t div_rsp;

  assign imm    = {s_q, d_q};
  assign rd     = d_q[2:0];
  assign rs     = s_q[2:0];
  assign pcn    = regs_q[acc_pkg::R_PC] + 16'd3;
  assign rv_d   = (rd == acc_pkg::R_PC) ? pcn : regs_q[rd];
  assign rv_s   = (rs == acc_pkg::R_PC) ? pcn : regs_q[rs];
  assign sp_dec = regs_q[acc_pkg::R_SP] - 16'd2;
  assign acc    = regs_q[acc_pkg::R_ACC];
  assign v      = rv_d;
  assign prod   = acc * v;

  // memory read address and divider launch
  always_comb begin
    needs_rd = 1'b0;
    rd_addr  = imm;
    if (req_q) begin
      needs_rd = 1'b1;
      rd_addr  = acc_pkg::VEC_ADDR;
    end else if (op_q >= acc_pkg::OP_LDM_X && op_q <= acc_pkg::OP_LDM_ACC) begin
      needs_rd = 1'b1;
    end else if (op_q == acc_pkg::OP_LDR) begin
      needs_rd = 1'b1;
      rd_addr  = rv_s;
    end else if (op_q == acc_pkg::OP_POP || op_q == acc_pkg::OP_RET) begin
      needs_rd = 1'b1;
      rd_addr  = regs_q[acc_pkg::R_SP];
    end
  end

  assign is_div = !req_q && op_q == acc_pkg::OP_ALU &&
                  (s_q == acc_pkg::ALU_DIV || s_q == acc_pkg::ALU_MOD);
  assign ra_lo  = rd_addr[ADDR_BITS-1:0];
  assign ra_hi  = ra_lo + ADDR_BITS'(1);

  assign div_req.start    = (state_q == S_DEC) && is_div;
  assign div_req.dividend = acc;
  assign div_req.divisor  = v;

  acc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // skip test on the stored flags
  always_comb begin
    fl = regs_q[acc_pkg::R_FL][2:0];
    unique case (d_q)
      acc_pkg::SK_NLT: skip = !fl[0];
      acc_pkg::SK_NGT: skip = !fl[1];
      acc_pkg::SK_NLE: skip = !(fl[0] | fl[2]);
      acc_pkg::SK_NGE: skip = !(fl[1] | fl[2]);
      acc_pkg::SK_NEQ: skip = !fl[2];
      acc_pkg::SK_LE:  skip = fl[0] | fl[2];
      default:         skip = 1'b0;
    endcase
  end

  // execute: new register values and the pending word write
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      regs_n[i] = regs_q[i];
    end
    wr_n    = 1'b0;
    waddr_n = sp_dec;
    wdata_n = regs_q[acc_pkg::R_PC];
    taken_n = 1'b0;
    if (req_q) begin
      if (word_q != 16'd0) begin
        regs_n[acc_pkg::R_SP] = sp_dec;
        regs_n[acc_pkg::R_PC] = word_q;
        wr_n    = 1'b1;
        taken_n = 1'b1;
      end
    end else begin
      regs_n[acc_pkg::R_PC] = pcn;
      if (op_q >= acc_pkg::OP_LDI_X && op_q <= acc_pkg::OP_LDI_ACC) begin
        regs_n[op_q[2:0] + 3'd2] = imm;
      end else if (op_q >= acc_pkg::OP_LDM_X && op_q <= acc_pkg::OP_LDM_ACC) begin
        regs_n[op_q[2:0] - 3'd3] = word_q;
      end else if (op_q >= acc_pkg::OP_STM_X && op_q <= acc_pkg::OP_STM_ACC) begin
        wr_n    = 1'b1;
        waddr_n = imm;
        wdata_n = regs_q[op_q[2:0] - 3'd2];
      end else begin
        unique case (op_q)
          acc_pkg::OP_MOV: regs_n[rd] = rv_s;
          acc_pkg::OP_LDR: regs_n[rd] = word_q;
          acc_pkg::OP_STR: begin
            wr_n    = 1'b1;
            waddr_n = rv_d;
            wdata_n = rv_s;
          end
          acc_pkg::OP_ALU: begin
            unique case (s_q)
              acc_pkg::ALU_ADD: regs_n[acc_pkg::R_ACC] = acc + v;
              acc_pkg::ALU_SUB: regs_n[acc_pkg::R_ACC] = acc - v;
              acc_pkg::ALU_MUL: regs_n[acc_pkg::R_ACC] = prod[15:0];
              acc_pkg::ALU_DIV:
                regs_n[acc_pkg::R_ACC] = (v == 16'd0) ? acc_pkg::ALL_ONES : div_rsp.quo;
              acc_pkg::ALU_MOD:
                regs_n[acc_pkg::R_ACC] = (v == 16'd0) ? acc : div_rsp.rem;
              acc_pkg::ALU_SHR:
                regs_n[acc_pkg::R_ACC] = (v >= 16'd16) ? 16'd0 : (acc >> v[3:0]);
              acc_pkg::ALU_SHL:
                regs_n[acc_pkg::R_ACC] = (v >= 16'd16) ? 16'd0 : (acc << v[3:0]);
              acc_pkg::ALU_AND: regs_n[acc_pkg::R_ACC] = acc & v;
              acc_pkg::ALU_OR:  regs_n[acc_pkg::R_ACC] = acc | v;
              acc_pkg::ALU_XOR: regs_n[acc_pkg::R_ACC] = acc ^ v;
              acc_pkg::ALU_NOT: regs_n[acc_pkg::R_ACC] = ~acc;
              acc_pkg::ALU_INC: regs_n[acc_pkg::R_ACC] = acc + 16'd1;
              default: ;
            endcase
          end
          acc_pkg::OP_CMP:
            regs_n[acc_pkg::R_FL] = {13'd0, rv_d == rv_s, rv_d > rv_s, rv_d < rv_s};
          acc_pkg::OP_CMPI:
            regs_n[acc_pkg::R_FL] = {13'd0, rv_d == {8'd0, s_q}, rv_d > {8'd0, s_q},
                                     rv_d < {8'd0, s_q}};
          acc_pkg::OP_SKIP: begin
            if (skip) begin
              regs_n[acc_pkg::R_PC] = pcn + 16'd3;
            end
          end
          acc_pkg::OP_JREL: begin
            // sign-magnitude offset from the instruction address
            if (imm[15]) begin
              regs_n[acc_pkg::R_PC] = regs_q[acc_pkg::R_PC] - (imm & acc_pkg::OFS_MASK);
            end else begin
              regs_n[acc_pkg::R_PC] = regs_q[acc_pkg::R_PC] + imm;
            end
          end
          acc_pkg::OP_JREG: begin
            if (s_q == 8'd0) begin
              regs_n[acc_pkg::R_PC] = regs_q[acc_pkg::R_PC] + regs_q[rd];
            end else begin
              regs_n[acc_pkg::R_PC] = regs_q[acc_pkg::R_PC] - regs_q[rs];
            end
          end
          acc_pkg::OP_JMP: regs_n[acc_pkg::R_PC] = imm;
          acc_pkg::OP_JR:  regs_n[acc_pkg::R_PC] = rv_d;
          acc_pkg::OP_PUSH: begin
            regs_n[acc_pkg::R_SP] = sp_dec;
            wr_n    = 1'b1;
            wdata_n = rv_d;
          end
          acc_pkg::OP_PUSHI: begin
            regs_n[acc_pkg::R_SP] = sp_dec;
            wr_n    = 1'b1;
            wdata_n = imm;
          end
          acc_pkg::OP_POP: begin
            regs_n[rd] = word_q;
            regs_n[acc_pkg::R_SP] = regs_n[acc_pkg::R_SP] + 16'd2;
          end
          acc_pkg::OP_CALL: begin
            regs_n[acc_pkg::R_SP] = sp_dec;
            regs_n[acc_pkg::R_PC] = imm;
            wr_n    = 1'b1;
            wdata_n = pcn;
          end
          acc_pkg::OP_RET: begin
            regs_n[acc_pkg::R_PC] = word_q;
            regs_n[acc_pkg::R_SP] = regs_q[acc_pkg::R_SP] + 16'd2;
          end
          acc_pkg::OP_INC: regs_n[rd] = rv_d + 16'd1;
          default: ;
        endcase
      end
    end
  end

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr_q[ADDR_BITS-1:0];
    ram_wdata = wdata_q[7:0];
    ram_raddr = ra_lo;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'd0;
      end
      S_RHI: ram_raddr = ra_hi;
      S_WLO: ram_we = 1'b1;
      S_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = waddr_q[ADDR_BITS-1:0] + ADDR_BITS'(1);
        ram_wdata = wdata_q[15:8];
      end
      default: ;
    endcase
  end

  acc_ram #(
    .ADDR_BITS (ADDR_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ADDR_BITS'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (needs_rd) begin
            state_q <= S_RHI;
          end else if (is_div) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_EXEC;
          end
        end
        S_RHI:  state_q <= S_RDY;
        S_RDY:  state_q <= S_EXEC;
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          for (int i = 0; i < 8; i++) begin
            regs_q[i] <= regs_n[i];
          end
          state_q <= wr_n ? S_WLO : S_FIN;
        end
        S_WLO:  state_q <= S_WHI;
        S_WHI:  state_q <= S_FIN;
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= req_type_i;
      op_q  <= opcode_i;
      d_q   <= dest_sel_i;
      s_q   <= src_sel_i;
    end
    if (state_q == S_RHI) begin
      lo_q <= ram_rdata;
    end
    if (state_q == S_RDY) begin
      word_q <= {ram_rdata, lo_q};
    end
    if (state_q == S_EXEC) begin
      wr_q    <= wr_n;
      waddr_q <= waddr_n;
      wdata_q <= wdata_n;
      taken_q <= taken_n;
    end
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
      next_pc_o   <= regs_q[1];
      stack_ptr_o <= regs_q[0];
      flag_bits_o <= regs_q[2][2:0];
      reg_x_o     <= regs_q[3];
      reg_y_o     <= regs_q[4];
      reg_a_o     <= regs_q[5];
      reg_b_o     <= regs_q[6];
      accum_o     <= regs_q[7];
      irq_taken_o <= taken_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while one is in flight");

  a_div_only_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> op_q == acc_pkg::OP_ALU && !req_q)
    else $error("divider wait outside an arithmetic instruction");

  a_write_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WLO |=> state_q == S_WHI && wr_q)
    else $error("word write split or issued without a pending store");

  a_irq_only_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && taken_q |-> req_q)
    else $error("interrupt reported for an instruction");

endmodule
`default_nettype wire

// ===== design/acc_ram.sv =====
// Byte-wide data memory, one write and one registered read port.
`default_nettype none
module acc_ram #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [7:0]           wdata_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [7:0]           rdata_o
);

  logic [7:0] mem [2**ADDR_BITS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/acc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module acc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire acc_pkg::div_req_t req_i,
  output acc_pkg::div_rsp_t      rsp_o
);

  logic [15:0] quo_q, rem_q, dvs_q;
  logic [3:0]  cnt_q;
  logic        busy_q, done_q;
  logic [16:0] shl, diff;

  assign shl  = {rem_q, quo_q[15]};
  assign diff = shl - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      // keep the shifted remainder when the trial subtract goes negative
      if (!diff[16]) begin
        rem_q <= diff[15:0];
      end else begin
        rem_q <= shl[15:0];
      end
      quo_q <= {quo_q[14:0], !diff[16]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== test/accumulator_cpu_core_16bit_test.sv =====
// Self-checking testbench of the accumulator core: directed table, then random programs.
`default_nettype none
module accumulator_cpu_core_16bit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 1000;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam logic [7:0]  OP_LDI_B     = 8'h04;
  localparam logic [7:0]  OP_BAD       = 8'hff;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [2:0]  fl;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] acc;
    logic        irq;
  } cpu_view_t;

  // typed = 1: pc, x, b, acc and irq below are the known values after the word
  typedef struct packed {
    logic        vblank;
    logic [7:0]  op;
    logic [7:0]  d;
    logic [7:0]  s;
    logic        typed;
    logic [15:0] pc;
    logic [15:0] x;
    logic [15:0] b;
    logic [15:0] acc;
    logic        irq;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic req_type_i = 1'b0;
  logic [7:0] opcode_i = '0;
  logic [7:0] dest_sel_i = '0;
  logic [7:0] src_sel_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, irq_taken_o;
  logic [15:0] next_pc_o, stack_ptr_o, reg_x_o, reg_y_o, reg_a_o, reg_b_o, accum_o;
  logic [2:0] flag_bits_o;

  logic [15:0] cpu_regs [8];
  logic [7:0]  cpu_mem [65536];
  cpu_view_t   pending_views[$];
  bit          failed = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;

  accumulator_cpu_core_16bit i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] mem_word(logic [15:0] addr);
    return {cpu_mem[addr + 16'd1], cpu_mem[addr]};
  endfunction

  function automatic void mem_store(logic [15:0] addr, logic [15:0] v);
    cpu_mem[addr] = v[7:0];
    cpu_mem[addr + 16'd1] = v[15:8];
  endfunction

  function automatic void stack_push(logic [15:0] v);
    cpu_regs[acc_pkg::R_SP] = cpu_regs[acc_pkg::R_SP] - 16'd2;
    mem_store(cpu_regs[acc_pkg::R_SP], v);
  endfunction

  function automatic void stack_pop(logic [2:0] r);
    cpu_regs[r] = mem_word(cpu_regs[acc_pkg::R_SP]);
    cpu_regs[acc_pkg::R_SP] = cpu_regs[acc_pkg::R_SP] + 16'd2;
  endfunction

  function automatic logic [15:0] alu_result(logic [15:0] acc, logic [15:0] v, logic [7:0] op);
    case (op)
      acc_pkg::ALU_ADD: return acc + v;
      acc_pkg::ALU_SUB: return acc - v;
      acc_pkg::ALU_MUL: return acc * v;
      acc_pkg::ALU_DIV: return (v == 0) ? acc_pkg::ALL_ONES : acc / v;
      acc_pkg::ALU_MOD: return (v == 0) ? acc : acc % v;
      acc_pkg::ALU_SHR: return (v >= 16) ? 16'd0 : acc >> v;
      acc_pkg::ALU_SHL: return (v >= 16) ? 16'd0 : acc << v;
      acc_pkg::ALU_AND: return acc & v;
      acc_pkg::ALU_OR:  return acc | v;
      acc_pkg::ALU_XOR: return acc ^ v;
      acc_pkg::ALU_NOT: return ~acc;
      acc_pkg::ALU_INC: return acc + 16'd1;
      default: return acc;
    endcase
  endfunction

  function automatic logic skip_taken(logic [15:0] f, logic [7:0] mode);
    case (mode)
      acc_pkg::SK_NLT: return !f[0];
      acc_pkg::SK_NGT: return !f[1];
      acc_pkg::SK_NLE: return !(f[0] | f[2]);
      acc_pkg::SK_NGE: return !(f[1] | f[2]);
      acc_pkg::SK_NEQ: return !f[2];
      acc_pkg::SK_LE:  return f[0] | f[2];
      default:         return 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] cmp_flags(logic [15:0] p, logic [15:0] q);
    return {13'd0, p == q, p > q, p < q};
  endfunction

  // Advance the core state by one word and return the registers it shows.
  function automatic cpu_view_t cpu_step(logic vblank, logic [7:0] op, logic [7:0] d,
                                         logic [7:0] s);
    cpu_view_t v;
    logic [15:0] imm, vec, here;
    logic [2:0] rd, rs;
    logic irq;
    imm = {s, d};
    rd = d[2:0];
    rs = s[2:0];
    irq = 1'b0;
    if (vblank) begin
      vec = mem_word(acc_pkg::VEC_ADDR);
      if (vec != 0) begin
        stack_push(cpu_regs[acc_pkg::R_PC]);
        cpu_regs[acc_pkg::R_PC] = vec;
        irq = 1'b1;
      end
    end else begin
      here = cpu_regs[acc_pkg::R_PC];
      cpu_regs[acc_pkg::R_PC] = here + 16'd3;
      if (op >= acc_pkg::OP_LDI_X && op <= acc_pkg::OP_LDI_ACC) begin
        cpu_regs[3'(op - acc_pkg::OP_LDI_X + 8'd3)] = imm;
      end else if (op >= acc_pkg::OP_LDM_X && op <= acc_pkg::OP_LDM_ACC) begin
        cpu_regs[3'(op - acc_pkg::OP_LDM_X + 8'd3)] = mem_word(imm);
      end else if (op >= acc_pkg::OP_STM_X && op <= acc_pkg::OP_STM_ACC) begin
        mem_store(imm, cpu_regs[3'(op - acc_pkg::OP_STM_X + 8'd3)]);
      end else begin
        case (op)
          acc_pkg::OP_MOV:   cpu_regs[rd] = cpu_regs[rs];
          acc_pkg::OP_LDR:   cpu_regs[rd] = mem_word(cpu_regs[rs]);
          acc_pkg::OP_STR:   mem_store(cpu_regs[rd], cpu_regs[rs]);
          acc_pkg::OP_ALU:
            cpu_regs[acc_pkg::R_ACC] = alu_result(cpu_regs[acc_pkg::R_ACC], cpu_regs[rd], s);
          acc_pkg::OP_CMP:   cpu_regs[acc_pkg::R_FL] = cmp_flags(cpu_regs[rd], cpu_regs[rs]);
          acc_pkg::OP_CMPI:  cpu_regs[acc_pkg::R_FL] = cmp_flags(cpu_regs[rd], {8'd0, s});
          acc_pkg::OP_SKIP:
            if (skip_taken(cpu_regs[acc_pkg::R_FL], d)) cpu_regs[acc_pkg::R_PC] = here + 16'd6;
          acc_pkg::OP_JREL:
            cpu_regs[acc_pkg::R_PC] = imm[15] ? here - (imm & acc_pkg::OFS_MASK) : here + imm;
          acc_pkg::OP_JREG: begin
            // register operands see the instruction address, not the advanced one
            cpu_regs[acc_pkg::R_PC] = here;
            cpu_regs[acc_pkg::R_PC] = (s == 0) ? here + cpu_regs[rd] : here - cpu_regs[rs];
          end
          acc_pkg::OP_JMP:   cpu_regs[acc_pkg::R_PC] = imm;
          acc_pkg::OP_JR:    cpu_regs[acc_pkg::R_PC] = cpu_regs[rd];
          acc_pkg::OP_PUSH:  stack_push(cpu_regs[rd]);
          acc_pkg::OP_PUSHI: stack_push(imm);
          acc_pkg::OP_POP:   stack_pop(rd);
          acc_pkg::OP_CALL: begin
            stack_push(cpu_regs[acc_pkg::R_PC]);
            cpu_regs[acc_pkg::R_PC] = imm;
          end
          acc_pkg::OP_RET:   stack_pop(acc_pkg::R_PC);
          acc_pkg::OP_INC:   cpu_regs[rd] = cpu_regs[rd] + 16'd1;
          default: ;
        endcase
      end
    end
    v.pc = cpu_regs[acc_pkg::R_PC];
    v.sp = cpu_regs[acc_pkg::R_SP];
    v.fl = cpu_regs[acc_pkg::R_FL][2:0];
    v.x = cpu_regs[3];
    v.y = cpu_regs[4];
    v.a = cpu_regs[5];
    v.b = cpu_regs[6];
    v.acc = cpu_regs[acc_pkg::R_ACC];
    v.irq = irq;
    return v;
  endfunction

  // Offer one word, keep it steady until accepted, queue its expected view.
  task automatic send_word(step_row_t r);
    cpu_view_t v;
    bit got;
    v = cpu_step(r.vblank, r.op, r.d, r.s);
    if (r.typed) begin
      v.pc = r.pc;
      v.x = r.x;
      v.b = r.b;
      v.acc = r.acc;
      v.irq = r.irq;
    end
    pending_views.push_back(v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = r.vblank;
    opcode_i = r.op;
    dest_sel_i = r.d;
    src_sel_i = r.s;
    do begin
      #1;
      got = in_ready_o;
      @(posedge clk_i);
    end while (!got);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Result side: random ready bursts, one long hold on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cpu_view_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_views.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_views.pop_front();
        if (next_pc_o !== e.pc) begin
          $error("next_pc exp %h got %h", e.pc, next_pc_o);
          failed = 1'b1;
        end
        if (stack_ptr_o !== e.sp) begin
          $error("stack_ptr exp %h got %h", e.sp, stack_ptr_o);
          failed = 1'b1;
        end
        if (flag_bits_o !== e.fl) begin
          $error("flag_bits exp %h got %h", e.fl, flag_bits_o);
          failed = 1'b1;
        end
        if (reg_x_o !== e.x) begin
          $error("reg_x exp %h got %h", e.x, reg_x_o);
          failed = 1'b1;
        end
        if (reg_y_o !== e.y) begin
          $error("reg_y exp %h got %h", e.y, reg_y_o);
          failed = 1'b1;
        end
        if (reg_a_o !== e.a) begin
          $error("reg_a exp %h got %h", e.a, reg_a_o);
          failed = 1'b1;
        end
        if (reg_b_o !== e.b) begin
          $error("reg_b exp %h got %h", e.b, reg_b_o);
          failed = 1'b1;
        end
        if (accum_o !== e.acc) begin
          $error("accum exp %h got %h", e.acc, accum_o);
          failed = 1'b1;
        end
        if (irq_taken_o !== e.irq) begin
          $error("irq_taken exp %h got %h", e.irq, irq_taken_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("accumulator_cpu_core_16bit regression: fail");
        $finish;
      end
    end
  end

  step_row_t directed_rows[] = '{
    '{0, acc_pkg::OP_LDI_X,   8'hff, 8'hff, 1, 16'd3,  16'hffff, 16'h0,  16'h0,    0},
    '{0, acc_pkg::OP_LDI_ACC, 8'h00, 8'h80, 1, 16'd6,  16'hffff, 16'h0,  16'h8000, 0},
    '{0, acc_pkg::OP_ALU,     8'h06, acc_pkg::ALU_DIV, 1, 16'd9, 16'hffff, 16'h0, 16'hffff, 0},
    '{0, acc_pkg::OP_ALU,     8'hfe, acc_pkg::ALU_MOD, 1, 16'd12, 16'hffff, 16'h0, 16'hffff,
      0},
    '{0, OP_LDI_B,            8'h20, 8'h00, 1, 16'd15, 16'hffff, 16'h20, 16'hffff, 0},
    '{0, acc_pkg::OP_ALU,     8'h06, acc_pkg::ALU_SHL, 1, 16'd18, 16'hffff, 16'h20, 16'h0, 0},
    '{0, OP_BAD,              8'hff, 8'hff, 1, 16'd21, 16'hffff, 16'h20, 16'h0,    0},
    '{1, 8'h00,               8'h00, 8'h00, 1, 16'd21, 16'hffff, 16'h20, 16'h0,    0},
    '{0, acc_pkg::OP_ALU,     8'h06, 8'h0c, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_STM_X,   8'h02, 8'hff, 0, 0, 0, 0, 0, 0},
    '{1, 8'hff,               8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_LDR,     8'h07, 8'hfb, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_STM_ACC, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_CMP,     8'h03, 8'h06, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_CMPI,    8'h06, 8'h20, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_SKIP,    acc_pkg::SK_NEQ, 8'h00, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_SKIP,    8'h06, 8'h00, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_JREL,    8'hff, 8'hff, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_JREG,    8'h06, 8'h00, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_JREG,    8'h00, 8'h06, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_JREG,    8'h01, 8'h00, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_JREG,    8'h00, 8'h01, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_CALL,    8'h34, 8'h12, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_RET,     8'h00, 8'h00, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_PUSHI,   8'h07, 8'h00, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_POP,     8'h00, 8'h00, 0, 0, 0, 0, 0, 0},
    '{0, acc_pkg::OP_MOV,     8'h02, 8'h03, 0, 0, 0, 0, 0, 0}
  };

  initial begin
    step_row_t r;
    int unsigned pick;
    for (int i = 0; i < 8; i++) cpu_regs[i] = '0;
    for (int i = 0; i < 65536; i++) cpu_mem[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed_rows[i]) send_word(directed_rows[i]);
    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - 100) quiet = 1'b1;
      r = '0;
      r.d = 8'($urandom_range(0, 255));
      r.s = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        r.vblank = 1'b1;
        r.op = 8'($urandom_range(0, 255));
      end else if (pick < 10) begin
        r.op = 8'($urandom_range(8'h20, 8'hff));
      end else begin
        r.op = 8'($urandom_range(acc_pkg::OP_MOV, acc_pkg::OP_INC));
        // keep most memory traffic in a small window, some on the vector
        if (r.op >= acc_pkg::OP_LDM_X && r.op <= acc_pkg::OP_STM_ACC &&
            r.op != acc_pkg::OP_LDR && r.op != acc_pkg::OP_STR) begin
          case ($urandom_range(0, 3))
            0: {r.s, r.d} = acc_pkg::VEC_ADDR;
            1: r.s = 8'hff;
            2: r.s = 8'h00;
            default: ;
          endcase
        end
        if (r.op == acc_pkg::OP_ALU && $urandom_range(0, 3) != 0) r.s = 8'($urandom_range(0, 12));
        if (r.op == acc_pkg::OP_SKIP && $urandom_range(0, 3) != 0) r.d = 8'($urandom_range(0, 6));
        if (r.op == acc_pkg::OP_JREG && $urandom_range(0, 1) == 0) r.s = 8'h00;
      end
      send_word(r);
    end
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (!failed) begin
      $display("accumulator_cpu_core_16bit regression: pass");
    end else begin
      $display("accumulator_cpu_core_16bit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
